// ----- sv/dal_pkg.sv -----
// Shared types and constants of the dynamic array list engine.
`timescale 1ns / 1ps

package dal_pkg;

  // Default number of entries in the value store.
  localparam int unsigned DalDepth = 256;

  // Fixed field widths.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_GET     = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_FIND    = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

endpackage

// ----- sv/dal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dal_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/dynamic_array_list_engine.sv -----
// Top level of the dynamic array list engine: sequencer, list state and result register.
`timescale 1ns / 1ps

// The engine keeps an ordered list of signed 32-bit values in a RAM of DEPTH entries,
// together with an entry count and a logical capacity, and answers every command with
// exactly one result transfer carrying status, data, count and capacity. Commands are
// taken one at a time: in_stall_o is low only while the sequencer is idle, and a
// finished result sits in an output register so that the next command can be taken
// while that result still waits. Append, clear, unknown codes and a get or remove whose
// index is out of range go straight to the finishing state; a get within range waits
// for the registered read; a remove within range shifts every later entry down a place,
// reverse swaps pairs from both ends inward, and find compares from index 0 to a match.
// The single store RAM has one write port and one registered read port, so every
// moved or compared entry takes a read and then a write or compare, and a swap takes
// two reads and two writes. Before an append and after a remove the capacity is
// adjusted: it doubles (up to DEPTH) when the count has reached it, and otherwise
// halves when the count is below a quarter of it. The store needs no clearing after
// reset, since only entries below the count are ever read.

module dynamic_array_list_engine #(
  parameter int unsigned DEPTH = dal_pkg::DalDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dal_pkg::CmdW-1:0]            cmd_i,
  input  logic signed [dal_pkg::ValW-1:0]     value_i,
  input  logic [dal_pkg::PosW-1:0]            position_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dal_pkg::StatusW-1:0]         status_o,
  output logic signed [dal_pkg::ValW-1:0]     data_o,
  output logic [$clog2(DEPTH+1)-1:0]          count_o,
  output logic [$clog2(DEPTH+1)-1:0]          capacity_now_o
);

  import dal_pkg::*;

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;

  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GET_WAIT,
    S_RM_RD,
    S_RM_WR,
    S_RM_FIN,
    S_RV_RDLO,
    S_RV_RDHI,
    S_RV_WRLO,
    S_RV_WRHI,
    S_FD_RD,
    S_FD_CMP,
    S_DONE
  } state_e;

  state_e state_q;

  // List state.
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] cap_q;

  // Working registers of the sequencer.
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] lo_q;
  logic [CntW-1:0] hi_q;
  logic [ValW-1:0] tmp_q;
  logic [ValW-1:0] value_q;
  status_e         res_status_q;
  logic [ValW-1:0] res_data_q;

  // Result register.
  logic            out_valid_q;
  status_e         out_status_q;
  logic [ValW-1:0] out_data_q;
  logic [CntW-1:0] out_count_q;
  logic [CntW-1:0] out_cap_q;

  // Store port signals.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ValW-1:0]  ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [ValW-1:0]  ram_rdata;

  logic            accept;
  cmd_e            cmd_in;
  logic [CmpW-1:0] pos_ext;
  logic            pos_in_range;
  logic            store_full;

  // Capacity rule: double (saturating at DEPTH) when the count has reached the capacity,
  // otherwise halve when the count is below a quarter of it and it is above one.
  function automatic logic [CntW-1:0] adjust_cap(input logic [CntW-1:0] cnt,
                                                 input logic [CntW-1:0] cap);
    logic [CntW:0] grown;
    grown = {cap, 1'b0};
    if (cnt == cap) begin
      return (grown > (CntW+1)'(DEPTH)) ? DepthCnt : grown[CntW-1:0];
    end else if ((cnt < (cap >> 2)) && (cap > CntOne)) begin
      return cap >> 1;
    end
    return cap;
  endfunction

  assign in_stall_o   = (state_q != S_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign cmd_in       = cmd_e'(cmd_i);
  assign pos_ext      = CmpW'(position_i);
  assign pos_in_range = pos_ext < CmpW'(count_q);
  assign store_full   = (count_q == DepthCnt);

  // Store addressing. The read port is steered by the sequencer state; the write port
  // serves appends on acceptance, the shift of a remove and both halves of a swap.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AddrW-1:0];
    ram_wdata = value_i;
    ram_raddr = pos_ext[AddrW-1:0];
    case (state_q)
      S_IDLE: begin
        ram_we = accept && (cmd_in == CMD_APPEND) && !store_full;
      end
      S_RM_RD: begin
        ram_raddr = AddrW'(idx_q + CntOne);
      end
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AddrW-1:0];
        ram_wdata = ram_rdata;
      end
      S_RV_RDLO: begin
        ram_raddr = lo_q[AddrW-1:0];
      end
      S_RV_RDHI: begin
        ram_raddr = hi_q[AddrW-1:0];
      end
      S_RV_WRLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AddrW-1:0];
        ram_wdata = ram_rdata;
      end
      S_RV_WRHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q[AddrW-1:0];
        ram_wdata = tmp_q;
      end
      S_FD_RD: begin
        ram_raddr = idx_q[AddrW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dal_ram #(
    .Width (ValW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, list state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      cap_q        <= CntOne;
      idx_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      tmp_q        <= '0;
      value_q      <= '0;
      res_status_q <= ST_OK;
      res_data_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_data_q   <= '0;
      out_count_q  <= '0;
      out_cap_q    <= CntOne;
    end else begin
      // The result register empties once its transfer completes.
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_status_q <= ST_OK;
            res_data_q   <= '0;
            value_q      <= value_i;
            state_q      <= S_DONE;
            case (cmd_in)
              CMD_APPEND: begin
                cap_q <= adjust_cap(count_q, cap_q);
                if (store_full) begin
                  res_status_q <= ST_FULL;
                  res_data_q   <= '1;
                end else begin
                  count_q <= count_q + CntOne;
                end
              end
              CMD_GET: begin
                if (pos_in_range) begin
                  state_q <= S_GET_WAIT;
                end else begin
                  res_status_q <= ST_RANGE;
                  res_data_q   <= '1;
                end
              end
              CMD_REMOVE: begin
                if (pos_in_range) begin
                  idx_q <= pos_ext[CntW-1:0];
                  if ((pos_ext + CmpW'(1)) < CmpW'(count_q)) begin
                    state_q <= S_RM_RD;
                  end else begin
                    state_q <= S_RM_FIN;
                  end
                end else begin
                  res_status_q <= ST_RANGE;
                  res_data_q   <= '1;
                  cap_q        <= adjust_cap(count_q, cap_q);
                end
              end
              CMD_REVERSE: begin
                if (count_q > CntOne) begin
                  lo_q    <= '0;
                  hi_q    <= count_q - CntOne;
                  state_q <= S_RV_RDLO;
                end
              end
              CMD_FIND: begin
                if (count_q == '0) begin
                  res_status_q <= ST_NOTFOUND;
                  res_data_q   <= '1;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_FD_RD;
                end
              end
              CMD_CLEAR: begin
                count_q <= '0;
                cap_q   <= CntOne;
              end
              default: begin
                // Codes without meaning leave the state alone and report success.
                res_status_q <= ST_OK;
              end
            endcase
          end
        end

        S_GET_WAIT: begin
          res_data_q <= ram_rdata;
          state_q    <= S_DONE;
        end

        S_RM_RD: begin
          state_q <= S_RM_WR;
        end

        S_RM_WR: begin
          if (({1'b0, idx_q} + (CntW+1)'(2)) < {1'b0, count_q}) begin
            idx_q   <= idx_q + CntOne;
            state_q <= S_RM_RD;
          end else begin
            state_q <= S_RM_FIN;
          end
        end

        S_RM_FIN: begin
          count_q <= count_q - CntOne;
          cap_q   <= adjust_cap(count_q - CntOne, cap_q);
          state_q <= S_DONE;
        end

        S_RV_RDLO: begin
          state_q <= S_RV_RDHI;
        end

        S_RV_RDHI: begin
          tmp_q   <= ram_rdata;
          state_q <= S_RV_WRLO;
        end

        S_RV_WRLO: begin
          state_q <= S_RV_WRHI;
        end

        S_RV_WRHI: begin
          lo_q <= lo_q + CntOne;
          hi_q <= hi_q - CntOne;
          if ((lo_q + CntOne) < (hi_q - CntOne)) begin
            state_q <= S_RV_RDLO;
          end else begin
            state_q <= S_DONE;
          end
        end

        S_FD_RD: begin
          state_q <= S_FD_CMP;
        end

        S_FD_CMP: begin
          if (ram_rdata == value_q) begin
            res_data_q <= ValW'(idx_q);
            state_q    <= S_DONE;
          end else if ((idx_q + CntOne) < count_q) begin
            idx_q   <= idx_q + CntOne;
            state_q <= S_FD_RD;
          end else begin
            res_status_q <= ST_NOTFOUND;
            res_data_q   <= '1;
            state_q      <= S_DONE;
          end
        end

        S_DONE: begin
          // Load the result once the register is free or being emptied this cycle.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_data_q   <= res_data_q;
            out_count_q  <= count_q;
            out_cap_q    <= cap_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign data_o         = out_data_q;
  assign count_o        = out_count_q;
  assign capacity_now_o = out_cap_q;

`ifndef SYNTHESIS
  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count exceeds the store depth");

  a_cap_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q >= CntOne) && (cap_q <= DepthCnt))
    else $error("capacity left its legal range");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("command taken but sequencer did not leave idle");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished command");

  a_swap_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RV_WRHI) |-> (lo_q < hi_q))
    else $error("reverse swapped an unordered pair");
`endif

endmodule
